// File: src/rsa_pkg.sv
// Shared types and constants for the reference-counted slot allocator.
// Used by the controller, the datapath, the top level and the checker.
package rsa_pkg;

    localparam int ADDR_W      = 8;
    localparam int CNT_OUT_W   = 16;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int ADDR_SPACE  = 2 ** ADDR_W;

    localparam int DEF_SLOT_COUNT  = 256;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INC   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEC   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] slot_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    result_addr;
        logic [CNT_OUT_W-1:0] count_after;
        logic                 slot_freed;
        logic [STATUS_W-1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic req_known;
    } sts_t;

endpackage

// File: src/refcounted_slot_allocator.sv
// Reference-counted slot allocator: one result item per allocate, increment
// or decrement item. An accepted item is registered with its memory reads,
// then committed to the output register once the output is free; no new
// item is accepted before that. Asynchronous active-low reset clears the
// live marks, stack pointer and high-water mark at once; no clearing pass.
// Depends on rsa_pkg, rsa_ctrl and rsa_datapath.
module refcounted_slot_allocator
#(
    parameter int SLOT_COUNT  = rsa_pkg::DEF_SLOT_COUNT,
    parameter int COUNT_WIDTH = rsa_pkg::DEF_COUNT_WIDTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rsa_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rsa_pkg::rsp_t  out_data
);

    rsa_pkg::cmd_t cmd;
    rsa_pkg::sts_t sts;

    rsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rsa_datapath
    #(
        .SLOT_COUNT  (SLOT_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

// File: src/rsa_ctrl.sv
// Control state machine for the slot allocator: sequences capture and commit
// of one item and owns the output valid flag. Depends on rsa_pkg.
module rsa_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rsa_pkg::sts_t    sts,
    output rsa_pkg::cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.req_known)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/rsa_datapath.sv
// Datapath of the slot allocator: count memory, free stack memory, live marks,
// stack pointer, high-water mark and the output register. Depends on rsa_pkg.
module rsa_datapath
#(
    parameter int SLOT_COUNT  = rsa_pkg::DEF_SLOT_COUNT,
    parameter int COUNT_WIDTH = rsa_pkg::DEF_COUNT_WIDTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  rsa_pkg::req_t  in_data,
    input  rsa_pkg::cmd_t  cmd,
    output rsa_pkg::sts_t  sts,
    output rsa_pkg::rsp_t  out_data
);

    // Only slots below both SLOT_COUNT and the 8-bit address space can ever be
    // addressed, pushed or counted, so storage covers just those.
    localparam int LIVE_DEPTH = (SLOT_COUNT < rsa_pkg::ADDR_SPACE) ?
                                SLOT_COUNT : rsa_pkg::ADDR_SPACE;
    localparam int LIVE_AW    = $clog2(LIVE_DEPTH);
    localparam int TOP_W      = $clog2(LIVE_DEPTH + 1);
    localparam int HW_W       = $clog2(SLOT_COUNT + 1);

    logic [COUNT_WIDTH-1:0] count_mem [LIVE_DEPTH];
    logic [LIVE_AW-1:0]     stack_mem [LIVE_DEPTH];

    rsa_pkg::req_t          req_reg;
    logic [COUNT_WIDTH-1:0] count_rd_reg;
    logic [LIVE_AW-1:0]     stack_rd_reg;
    rsa_pkg::rsp_t          rsp_reg;
    rsa_pkg::rsp_t          rsp_next;

    logic [TOP_W-1:0]       free_top_reg;
    logic [TOP_W-1:0]       free_top_next;
    logic [HW_W-1:0]        hw_reg;
    logic [HW_W-1:0]        hw_next;
    logic [LIVE_DEPTH-1:0]  live_reg;
    logic [LIVE_DEPTH-1:0]  live_next;

    logic [TOP_W-1:0]       top_dec;
    logic [LIVE_AW-1:0]     req_idx;
    logic                   is_alloc;
    logic                   is_inc;
    logic                   is_dec;
    logic                   addr_in_range;
    logic                   live_ok;
    logic                   stack_nonempty;
    logic                   hw_avail;
    logic [HW_W-1:0]        alloc_slot;
    logic [31:0]            alloc_ext;
    logic                   alloc_in_live;
    logic                   cnt_sat;
    logic                   cnt_low;

    logic                   cnt_we;
    logic [LIVE_AW-1:0]     cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   stk_we;

    logic [COUNT_WIDTH-1:0] new_count;
    logic [31:0]            new_count_ext;
    logic [rsa_pkg::ADDR_W-1:0]   res_addr;
    logic                   res_freed;
    logic [rsa_pkg::STATUS_W-1:0] res_status;

    assign top_dec        = free_top_reg - 1'b1;
    assign req_idx        = req_reg.slot_addr[LIVE_AW-1:0];
    assign is_alloc       = (req_reg.req_type == rsa_pkg::REQ_ALLOC);
    assign is_inc         = (req_reg.req_type == rsa_pkg::REQ_INC);
    assign is_dec         = (req_reg.req_type == rsa_pkg::REQ_DEC);
    assign sts.req_known  = is_alloc || is_inc || is_dec;
    assign addr_in_range  = (32'(req_reg.slot_addr) < LIVE_DEPTH);
    assign live_ok        = addr_in_range && live_reg[req_idx];
    assign stack_nonempty = (free_top_reg != '0);
    assign hw_avail       = (32'(hw_reg) < SLOT_COUNT);
    assign alloc_slot     = stack_nonempty ? HW_W'(stack_rd_reg) : hw_reg;
    assign alloc_ext      = 32'(alloc_slot);
    assign alloc_in_live  = (alloc_ext < LIVE_DEPTH);
    assign cnt_sat        = (count_rd_reg == '1);
    assign cnt_low        = (count_rd_reg == '0) || (count_rd_reg == COUNT_WIDTH'(1));
    assign new_count_ext  = 32'(new_count);

    always_comb
    begin
        free_top_next = free_top_reg;
        hw_next       = hw_reg;
        live_next     = live_reg;
        cnt_we        = 1'b0;
        cnt_waddr     = req_idx;
        cnt_wdata     = '0;
        stk_we        = 1'b0;
        new_count     = '0;
        res_addr      = req_reg.slot_addr;
        res_freed     = 1'b0;
        res_status    = rsa_pkg::STATUS_OK;
        case (req_reg.req_type)
            rsa_pkg::REQ_ALLOC:
            begin
                if (stack_nonempty || hw_avail)
                begin
                    res_addr = alloc_ext[rsa_pkg::ADDR_W-1:0];
                    if (stack_nonempty)
                    begin
                        free_top_next = top_dec;
                    end
                    else
                    begin
                        hw_next = hw_reg + 1'b1;
                    end
                    if (alloc_in_live)
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = alloc_slot[LIVE_AW-1:0];
                        live_next[alloc_slot[LIVE_AW-1:0]] = 1'b1;
                    end
                end
                else
                begin
                    res_addr   = '0;
                    res_status = rsa_pkg::STATUS_FULL;
                end
            end
            rsa_pkg::REQ_INC:
            begin
                if (!live_ok)
                begin
                    res_status = rsa_pkg::STATUS_NOT_LIVE;
                end
                else if (cnt_sat)
                begin
                    new_count  = count_rd_reg;
                    res_status = rsa_pkg::STATUS_SAT;
                end
                else
                begin
                    new_count = count_rd_reg + 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = new_count;
                end
            end
            rsa_pkg::REQ_DEC:
            begin
                if (!live_ok)
                begin
                    res_status = rsa_pkg::STATUS_NOT_LIVE;
                end
                else if (cnt_low)
                begin
                    cnt_we             = 1'b1;
                    live_next[req_idx] = 1'b0;
                    res_freed          = 1'b1;
                    if (32'(free_top_reg) < LIVE_DEPTH)
                    begin
                        stk_we        = 1'b1;
                        free_top_next = free_top_reg + 1'b1;
                    end
                end
                else
                begin
                    new_count = count_rd_reg - 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = new_count;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_next.result_addr = res_addr;
        rsp_next.count_after = new_count_ext[rsa_pkg::CNT_OUT_W-1:0];
        rsp_next.slot_freed  = res_freed;
        rsp_next.status      = res_status;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= in_data;
            count_rd_reg <= count_mem[in_data.slot_addr[LIVE_AW-1:0]];
            stack_rd_reg <= stack_mem[top_dec[LIVE_AW-1:0]];
        end
        if (cmd.commit && cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.commit && stk_we)
        begin
            stack_mem[free_top_reg[LIVE_AW-1:0]] <= req_idx;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg <= '0;
            hw_reg       <= '0;
            live_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            free_top_reg <= free_top_next;
            hw_reg       <= hw_next;
            live_reg     <= live_next;
        end
    end

    assign out_data = rsp_reg;

endmodule

// File: src/rsa_checker.sv
// Port-level checker for the slot allocator and its bind to the top level.
// Depends on rsa_pkg.
module rsa_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input rsa_pkg::req_t in_data,
    input logic          out_valid,
    input logic          out_ready,
    input rsa_pkg::rsp_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result item changed or dropped.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Item accepted while the previous one was in progress.");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == rsa_pkg::STATUS_FULL |->
        out_data.result_addr == '0 && out_data.count_after == '0 && !out_data.slot_freed)
        else $error("Pool full result carries nonzero fields.");

    a_freed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.slot_freed |->
        out_data.status == rsa_pkg::STATUS_OK && out_data.count_after == '0)
        else $error("Freed slot reported with nonzero count or bad status.");

    a_not_live_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == rsa_pkg::STATUS_NOT_LIVE |->
        out_data.count_after == '0 && !out_data.slot_freed)
        else $error("Not-live result carries a count or a free.");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_slot_allocator: directed, count and random items
// are checked against a slot-pool predictor kept in this file. Depends on rsa_pkg and the RTL.
module testbench;

    localparam int ADDR_W = rsa_pkg::ADDR_W;
    localparam int CNT_OUT_W = rsa_pkg::CNT_OUT_W;
    localparam logic [rsa_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int unsigned COUNT_CEIL = (1 << rsa_pkg::DEF_COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int FREE_AFTER_FULL = 48;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    rsa_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsa_pkg::rsp_t out_data;

    int send_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_req_seq = 0;
    int hold_seen_seq = 0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    rsa_pkg::rsp_t expected_rsp [$];

    int unsigned cnt_mem [rsa_pkg::DEF_SLOT_COUNT];
    logic [ADDR_W-1:0] free_lifo [rsa_pkg::DEF_SLOT_COUNT];
    bit is_live [rsa_pkg::DEF_SLOT_COUNT];
    int unsigned lifo_depth = 0;
    int unsigned next_fresh = 0;
    logic [ADDR_W-1:0] last_granted = '0;

    refcounted_slot_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic bit apply_request(input rsa_pkg::req_t r, output rsa_pkg::rsp_t rsp);
        int unsigned slot;
        rsp = '0;
        rsp.result_addr = r.slot_addr;
        case (r.req_type)
            rsa_pkg::REQ_ALLOC:
            begin
                rsp.result_addr = '0;
                if (lifo_depth > 0)
                begin
                    lifo_depth--;
                    slot = free_lifo[lifo_depth];
                end
                else if (next_fresh < rsa_pkg::DEF_SLOT_COUNT)
                begin
                    slot = next_fresh;
                    next_fresh++;
                end
                else
                begin
                    rsp.status = rsa_pkg::STATUS_FULL;
                    return 1'b1;
                end
                cnt_mem[slot] = 0;
                is_live[slot] = 1'b1;
                last_granted = ADDR_W'(slot);
                rsp.result_addr = ADDR_W'(slot);
                rsp.status = rsa_pkg::STATUS_OK;
                return 1'b1;
            end
            rsa_pkg::REQ_INC, rsa_pkg::REQ_DEC:
            begin
                slot = r.slot_addr;
                if (!is_live[slot])
                begin
                    rsp.status = rsa_pkg::STATUS_NOT_LIVE;
                end
                else if (r.req_type == rsa_pkg::REQ_INC)
                begin
                    if (cnt_mem[slot] >= COUNT_CEIL)
                    begin
                        cnt_mem[slot] = COUNT_CEIL;
                        rsp.status = rsa_pkg::STATUS_SAT;
                    end
                    else
                    begin
                        cnt_mem[slot]++;
                        rsp.status = rsa_pkg::STATUS_OK;
                    end
                    rsp.count_after = CNT_OUT_W'(cnt_mem[slot]);
                end
                else if (cnt_mem[slot] <= 1)
                begin
                    cnt_mem[slot] = 0;
                    is_live[slot] = 1'b0;
                    free_lifo[lifo_depth] = r.slot_addr;
                    lifo_depth++;
                    rsp.slot_freed = 1'b1;
                    rsp.status = rsa_pkg::STATUS_OK;
                end
                else
                begin
                    cnt_mem[slot]--;
                    rsp.count_after = CNT_OUT_W'(cnt_mem[slot]);
                    rsp.status = rsa_pkg::STATUS_OK;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_live_slot();
        logic [ADDR_W-1:0] live_q [$];
        for (int s = 0; s < rsa_pkg::DEF_SLOT_COUNT; s++)
        begin
            if (is_live[s])
                live_q.insert(live_q.size(), ADDR_W'(s));
        end
        if (live_q.size() == 0)
            return ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1));
        return live_q[$urandom_range(live_q.size() - 1)];
    endfunction

    task automatic send_req(input logic [rsa_pkg::REQ_W-1:0] kind,
                            input logic [ADDR_W-1:0] addr);
        rsa_pkg::req_t r;
        rsa_pkg::rsp_t want;
        r.req_type = kind;
        r.slot_addr = addr;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        if (apply_request(r, want))
            expected_rsp.insert(expected_rsp.size(), want);
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsa_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result item with none expected: result_addr %0d status %0d",
                       out_data.result_addr, out_data.status);
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (out_data.result_addr !== want.result_addr)
                begin
                    $error("result_addr: expected %0d, got %0d",
                           want.result_addr, out_data.result_addr);
                    fail_count++;
                end
                if (out_data.count_after !== want.count_after)
                begin
                    $error("count_after: expected %0d, got %0d",
                           want.count_after, out_data.count_after);
                    fail_count++;
                end
                if (out_data.slot_freed !== want.slot_freed)
                begin
                    $error("slot_freed: expected %0d, got %0d",
                           want.slot_freed, out_data.slot_freed);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : rcv_drive
        if (hold_seen_seq != hold_req_seq)
        begin
            hold_seen_seq = hold_req_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        send_req(rsa_pkg::REQ_INC, 8'h00);
        send_req(rsa_pkg::REQ_DEC, 8'hFF);
        send_req(REQ_UNKNOWN, 8'hFF);
        send_req(rsa_pkg::REQ_ALLOC, 8'hFF);
        send_req(rsa_pkg::REQ_ALLOC, 8'h00);
        send_req(rsa_pkg::REQ_INC, 8'h00);
        send_req(rsa_pkg::REQ_INC, 8'h00);
        send_req(rsa_pkg::REQ_DEC, 8'h00);
        send_req(rsa_pkg::REQ_DEC, 8'h00);
        send_req(rsa_pkg::REQ_DEC, 8'h00);
        send_req(rsa_pkg::REQ_INC, 8'h00);
        send_req(rsa_pkg::REQ_ALLOC, 8'h55);
        send_req(rsa_pkg::REQ_DEC, 8'h00);
        send_req(rsa_pkg::REQ_DEC, 8'h01);
        send_req(rsa_pkg::REQ_ALLOC, 8'hAA);
        send_req(rsa_pkg::REQ_ALLOC, 8'h00);
        send_req(rsa_pkg::REQ_ALLOC, 8'h00);
        send_req(REQ_UNKNOWN, 8'h00);
        send_req(rsa_pkg::REQ_INC, 8'h02);
    endtask

    task automatic test_pool_full();
        logic [ADDR_W-1:0] order [rsa_pkg::DEF_SLOT_COUNT];
        logic [ADDR_W-1:0] swap_tmp;
        int j;
        while (lifo_depth != 0 || next_fresh < rsa_pkg::DEF_SLOT_COUNT)
            send_req(rsa_pkg::REQ_ALLOC, ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1)));
        send_req(rsa_pkg::REQ_ALLOC, 8'h00);
        send_req(rsa_pkg::REQ_ALLOC, 8'hFF);
        send_req(rsa_pkg::REQ_INC, 8'hFF);
        send_req(rsa_pkg::REQ_DEC, 8'hFF);
        send_req(rsa_pkg::REQ_ALLOC, 8'h00);
        for (int i = 0; i < rsa_pkg::DEF_SLOT_COUNT; i++)
            order[i] = ADDR_W'(i);
        for (int i = rsa_pkg::DEF_SLOT_COUNT - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            swap_tmp = order[i];
            order[i] = order[j];
            order[j] = swap_tmp;
        end
        for (int i = 0; i < FREE_AFTER_FULL; i++)
            send_req(rsa_pkg::REQ_DEC, order[i]);
    endtask

    task automatic test_count_run();
        logic [ADDR_W-1:0] slot;
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        send_req(rsa_pkg::REQ_ALLOC, 8'hFF);
        slot = last_granted;
        repeat (12)
            send_req(rsa_pkg::REQ_INC, slot);
        repeat (13)
            send_req(rsa_pkg::REQ_DEC, slot);
    endtask

    task automatic test_random(input int send_pct, input int rcv_pct, input int n_items);
        int sent;
        int pick;
        send_idle_pct = send_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                send_req(REQ_UNKNOWN, ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1)));
            end
            else
            begin
                if (pick < 35)
                    send_req(rsa_pkg::REQ_ALLOC,
                             ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1)));
                else if (pick < 60)
                    send_req(rsa_pkg::REQ_INC, pick_live_slot());
                else if (pick < 88)
                    send_req(rsa_pkg::REQ_DEC, pick_live_slot());
                else
                    send_req($urandom_range(1) ? rsa_pkg::REQ_INC : rsa_pkg::REQ_DEC,
                             ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1)));
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req_seq++;
        repeat (20)
        begin
            if ($urandom_range(1))
                send_req(rsa_pkg::REQ_ALLOC, ADDR_W'($urandom_range(rsa_pkg::ADDR_SPACE - 1)));
            else
                send_req(rsa_pkg::REQ_INC, pick_live_slot());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_full();
        test_count_run();
        test_random(16, 72, 40);
        test_random(72, 16, 40);
        test_random(0, 0, 40);
        test_backpressure();
        in_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
